FILE: src/tnsi_pkg.sv
// Shared types and constants for the tour node-swap improver.
`timescale 1ns / 1ps

package tnsi_pkg;

   localparam int MaxCities = 32;
   localparam int CityBits  = 5;
   localparam int DistBits  = 20;
   localparam int LenBits   = 25;
   localparam int CountBits = 6;
   localparam int PhaseBits = 4;

   localparam logic [LenBits-1:0]   LenMax     = {LenBits{1'b1}};
   localparam logic [CountBits-1:0] CountReset = 6'd30;
   localparam logic [CountBits-1:0] CountMin   = 6'd4;
   localparam logic [CountBits-1:0] CountMax   = 6'd32;

   // Operation codes carried in the request tuser
   localparam logic [1:0] OP_LOAD_DIST = 2'd0;
   localparam logic [1:0] OP_LOAD_TOUR = 2'd1;
   localparam logic [1:0] OP_RUN       = 2'd2;
   localparam logic [1:0] OP_SPARE     = 2'd3;

   // Tour capture slots
   localparam logic [1:0] SLOT_A = 2'd0;
   localparam logic [1:0] SLOT_B = 2'd1;
   localparam logic [1:0] SLOT_C = 2'd2;
   localparam logic [1:0] SLOT_D = 2'd3;

   // Distance pairs, also the capture slot of each distance
   localparam logic [1:0] PAIR_AB = 2'd0;
   localparam logic [1:0] PAIR_CD = 2'd1;
   localparam logic [1:0] PAIR_AC = 2'd2;
   localparam logic [1:0] PAIR_BD = 2'd3;

   typedef struct packed {
      logic                ld_dist;
      logic                ld_tour;
      logic                tour_rd;
      logic [CityBits-1:0] tour_addr;
      logic                tcap_en;
      logic [1:0]          tcap_sel;
      logic                dist_rd;
      logic [1:0]          pair_sel;
      logic                dcap_en;
      logic [1:0]          dcap_sel;
      logic                swap_wr;
      logic                swap_hi;
      logic                len_clr;
      logic                len_add;
      logic                out_load;
      logic [CityBits-1:0] out_pos;
      logic                out_last;
   } tnsi_cmd_type;

   typedef struct packed {
      logic take;
      logic out_free;
   } tnsi_stat_type;

endpackage

FILE: src/tnsi_ctrl.sv
// Sequencer for loads, swap sweeps, length sum and result emission.
`timescale 1ns / 1ps

module tnsi_ctrl
   import tnsi_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CountBits-1:0] csr_wdata,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [1:0]           req_tuser,
   input  tnsi_stat_type        stat,
   output tnsi_cmd_type         cmd
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SWEEP = 2'd1;
   localparam logic [1:0] S_LEN   = 2'd2;
   localparam logic [1:0] S_EMIT  = 2'd3;

   localparam logic [PhaseBits-1:0] PH_SWEEP_END = 4'd11;
   localparam logic [PhaseBits-1:0] PH_LEN_END   = 4'd4;
   localparam logic [PhaseBits-1:0] PH_EMIT_END  = 4'd1;

   logic [CountBits-1:0] count_ff, count_in;
   logic [1:0]           state_ff, state_in;
   logic [PhaseBits-1:0] phase_ff, phase_in;
   logic [CountBits-1:0] n_ff, n_in;
   logic [CountBits-1:0] span_ff, span_in;
   logic [CountBits-1:0] off_ff, off_in;
   logic [CountBits-1:0] pos_ff, pos_in;

   logic [CountBits-1:0] n_clamp, pos_inc, p1;
   logic [CountBits:0]   sum2, sum3, p2w, p3w;
   logic                 accept, pos_end;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid & req_tready;

   // Clamp the city count into the supported range
   always_comb begin
      n_clamp = count_ff;
      if (count_ff < CountMin) n_clamp = CountMin;
      if (count_ff > CountMax) n_clamp = CountMax;
   end

   // Tour positions of the current step, wrapped once
   assign pos_inc = pos_ff + 6'd1;
   assign p1      = (pos_inc == n_ff) ? '0 : pos_inc;
   assign sum2    = {1'b0, pos_ff} + {1'b0, off_ff} - 7'd2;
   assign sum3    = {1'b0, pos_ff} + {1'b0, off_ff} - 7'd1;
   assign p2w     = (sum2 >= {1'b0, n_ff}) ? sum2 - {1'b0, n_ff} : sum2;
   assign p3w     = (sum3 >= {1'b0, n_ff}) ? sum3 - {1'b0, n_ff} : sum3;
   assign pos_end = (pos_inc == n_ff);

   // Commands and next state
   always_comb begin
      cmd      = '0;
      count_in = csr_we ? csr_wdata : count_ff;
      state_in = state_ff;
      phase_in = phase_ff + 4'd1;
      n_in     = n_ff;
      span_in  = span_ff;
      off_in   = off_ff;
      pos_in   = pos_ff;
      case (state_ff)
         S_IDLE: begin
            phase_in = '0;
            if (accept) begin
               case (req_tuser)
                  OP_LOAD_DIST: cmd.ld_dist = 1'b1;
                  OP_LOAD_TOUR: cmd.ld_tour = 1'b1;
                  OP_RUN: begin
                     cmd.len_clr = 1'b1;
                     n_in     = n_clamp;
                     span_in  = n_clamp;
                     off_in   = n_clamp;
                     pos_in   = '0;
                     state_in = S_SWEEP;
                  end
                  default: ;
               endcase
            end
         end
         S_SWEEP: begin
            case (phase_ff)
               4'd0: begin
                  cmd.tour_rd = 1'b1; cmd.tour_addr = pos_ff[CityBits-1:0];
               end
               4'd1: begin
                  cmd.tour_rd = 1'b1; cmd.tour_addr = p1[CityBits-1:0];
                  cmd.tcap_en = 1'b1; cmd.tcap_sel = SLOT_A;
               end
               4'd2: begin
                  cmd.tour_rd = 1'b1; cmd.tour_addr = p2w[CityBits-1:0];
                  cmd.tcap_en = 1'b1; cmd.tcap_sel = SLOT_B;
               end
               4'd3: begin
                  cmd.tour_rd = 1'b1; cmd.tour_addr = p3w[CityBits-1:0];
                  cmd.tcap_en = 1'b1; cmd.tcap_sel = SLOT_C;
               end
               4'd4: begin
                  cmd.tcap_en = 1'b1; cmd.tcap_sel = SLOT_D;
               end
               4'd5: begin
                  cmd.dist_rd = 1'b1; cmd.pair_sel = PAIR_AB;
               end
               4'd6: begin
                  cmd.dist_rd = 1'b1; cmd.pair_sel = PAIR_CD;
                  cmd.dcap_en = 1'b1; cmd.dcap_sel = PAIR_AB;
               end
               4'd7: begin
                  cmd.dist_rd = 1'b1; cmd.pair_sel = PAIR_AC;
                  cmd.dcap_en = 1'b1; cmd.dcap_sel = PAIR_CD;
               end
               4'd8: begin
                  cmd.dist_rd = 1'b1; cmd.pair_sel = PAIR_BD;
                  cmd.dcap_en = 1'b1; cmd.dcap_sel = PAIR_AC;
               end
               4'd9: begin
                  cmd.dcap_en = 1'b1; cmd.dcap_sel = PAIR_BD;
               end
               4'd10: begin
                  cmd.tour_addr = p1[CityBits-1:0];
                  cmd.swap_wr   = stat.take;
               end
               PH_SWEEP_END: begin
                  cmd.tour_addr = p2w[CityBits-1:0];
                  cmd.swap_wr   = stat.take;
                  cmd.swap_hi   = 1'b1;
                  phase_in      = '0;
                  // Advance position, then offset, then span
                  if (pos_end) begin
                     pos_in = '0;
                     if (off_ff == CountMin) begin
                        span_in = span_ff - 6'd1;
                        off_in  = span_ff - 6'd1;
                        if (span_ff == CountMin) state_in = S_LEN;
                     end else begin
                        off_in = off_ff - 6'd1;
                     end
                  end else begin
                     pos_in = pos_inc;
                  end
               end
               default: phase_in = '0;
            endcase
         end
         S_LEN: begin
            case (phase_ff)
               4'd0: begin
                  cmd.tour_rd = 1'b1; cmd.tour_addr = pos_ff[CityBits-1:0];
               end
               4'd1: begin
                  cmd.tour_rd = 1'b1; cmd.tour_addr = p1[CityBits-1:0];
                  cmd.tcap_en = 1'b1; cmd.tcap_sel = SLOT_A;
               end
               4'd2: begin
                  cmd.tcap_en = 1'b1; cmd.tcap_sel = SLOT_B;
               end
               4'd3: begin
                  cmd.dist_rd = 1'b1; cmd.pair_sel = PAIR_AB;
               end
               PH_LEN_END: begin
                  cmd.len_add = 1'b1;
                  phase_in    = '0;
                  if (pos_end) begin
                     pos_in   = '0;
                     state_in = S_EMIT;
                  end else begin
                     pos_in = pos_inc;
                  end
               end
               default: phase_in = '0;
            endcase
         end
         S_EMIT: begin
            case (phase_ff)
               4'd0: begin
                  cmd.tour_rd = 1'b1; cmd.tour_addr = pos_ff[CityBits-1:0];
               end
               PH_EMIT_END: begin
                  // Hold until the output register can take a word
                  phase_in = phase_ff;
                  if (stat.out_free) begin
                     cmd.out_load = 1'b1;
                     cmd.out_pos  = pos_ff[CityBits-1:0];
                     cmd.out_last = pos_end;
                     phase_in     = '0;
                     if (pos_end) begin
                        pos_in   = '0;
                        state_in = S_IDLE;
                     end else begin
                        pos_in = pos_inc;
                     end
                  end
               end
               default: phase_in = '0;
            endcase
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CountReset;
         state_ff <= S_IDLE;
         phase_ff <= '0;
         n_ff     <= CountMin;
         span_ff  <= '0;
         off_ff   <= '0;
         pos_ff   <= '0;
      end else begin
         count_ff <= count_in;
         state_ff <= state_in;
         phase_ff <= phase_in;
         n_ff     <= n_in;
         span_ff  <= span_in;
         off_ff   <= off_in;
         pos_ff   <= pos_in;
      end
   end

endmodule

FILE: src/tnsi_dpath.sv
// Distance and tour memories, swap compare, length sum and output register.
`timescale 1ns / 1ps

module tnsi_dpath
   import tnsi_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  tnsi_cmd_type        cmd,
   output tnsi_stat_type       stat,
   input  logic [39:0]         req_tdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [39:0]         rsp_tdata,
   output logic                rsp_tlast
);

   logic [DistBits-1:0] dist_mem [MaxCities*MaxCities];
   logic [CityBits-1:0] tour_mem [MaxCities];

   logic [CityBits-1:0] tour_rd_ff;
   logic [DistBits-1:0] dist_rd_ff;
   logic [CityBits-1:0] city_ff [4];
   logic [DistBits-1:0] dval_ff [4];
   logic [LenBits-1:0]  len_ff, len_in;
   logic                vld_ff, vld_in;
   logic [CityBits-1:0] opos_ff, ocity_ff;
   logic [LenBits-1:0]  olen_ff;
   logic                olast_ff;

   logic [CityBits-1:0] ld_from, ld_to, ld_pos, ld_city;
   logic [DistBits-1:0] ld_dist;
   logic [2*CityBits-1:0] dist_addr;
   logic [DistBits:0]   now_sum, alt_sum;
   logic [LenBits:0]    len_sum;

   assign ld_from = req_tdata[4:0];
   assign ld_to   = req_tdata[9:5];
   assign ld_dist = req_tdata[29:10];
   assign ld_pos  = req_tdata[34:30];
   assign ld_city = req_tdata[39:35];

   // Pick the city pair for the distance lookup
   always_comb begin
      case (cmd.pair_sel)
         PAIR_AB: dist_addr = {city_ff[SLOT_A], city_ff[SLOT_B]};
         PAIR_CD: dist_addr = {city_ff[SLOT_C], city_ff[SLOT_D]};
         PAIR_AC: dist_addr = {city_ff[SLOT_A], city_ff[SLOT_C]};
         PAIR_BD: dist_addr = {city_ff[SLOT_B], city_ff[SLOT_D]};
         default: dist_addr = '0;
      endcase
   end

   // Distance memory: load writes, one registered read
   always_ff @(posedge clock) begin
      if (cmd.ld_dist) dist_mem[{ld_from, ld_to}] <= ld_dist;
      if (cmd.dist_rd) dist_rd_ff <= dist_mem[dist_addr];
   end

   // Tour memory: load or swap writes, one registered read
   always_ff @(posedge clock) begin
      if (cmd.ld_tour) begin
         tour_mem[ld_pos] <= ld_city;
      end else if (cmd.swap_wr) begin
         tour_mem[cmd.tour_addr] <= cmd.swap_hi ? city_ff[SLOT_B] : city_ff[SLOT_C];
      end
      if (cmd.tour_rd) tour_rd_ff <= tour_mem[cmd.tour_addr];
   end

   // Capture cities and distances of the current step
   always_ff @(posedge clock) begin
      if (cmd.tcap_en) city_ff[cmd.tcap_sel] <= tour_rd_ff;
      if (cmd.dcap_en) dval_ff[cmd.dcap_sel] <= dist_rd_ff;
   end

   // Swap when the crossed pair is strictly shorter
   assign now_sum   = {1'b0, dval_ff[PAIR_AB]} + {1'b0, dval_ff[PAIR_CD]};
   assign alt_sum   = {1'b0, dval_ff[PAIR_AC]} + {1'b0, dval_ff[PAIR_BD]};
   assign stat.take = (now_sum > alt_sum);

   // Saturating tour length sum
   assign len_sum = {1'b0, len_ff} + {{(LenBits-DistBits+1){1'b0}}, dist_rd_ff};
   always_comb begin
      len_in = len_ff;
      if (cmd.len_clr) len_in = '0;
      else if (cmd.len_add) len_in = len_sum[LenBits] ? LenMax : len_sum[LenBits-1:0];
   end

   // Output register
   assign stat.out_free = !vld_ff || rsp_tready;
   always_comb begin
      vld_in = vld_ff;
      if (cmd.out_load) vld_in = 1'b1;
      else if (rsp_tready) vld_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
         len_ff <= '0;
      end else begin
         vld_ff <= vld_in;
         len_ff <= len_in;
      end
   end

   // Hold the whole word, length included, so a new run cannot disturb it
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         opos_ff  <= cmd.out_pos;
         ocity_ff <= tour_rd_ff;
         olen_ff  <= len_ff;
         olast_ff <= cmd.out_last;
      end
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tlast  = olast_ff;
   assign rsp_tdata  = {5'd0, olen_ff, ocity_ff, opos_ff};

endmodule

FILE: src/tour_node_swap_improver.sv
// Top level of the tour node-swap improver.
// Load words (distance entries, tour positions) are taken one per cycle. A run
// word then performs the node-swap sweeps, one tested position at a time, as the
// tour and distance memories each have a single read port; the sweeps are
// followed by summing the tour length and emitting the n result words. No
// request is taken from the run word until the final result word has been
// loaded into the output register. The length saturates at 2^25-1.
`timescale 1ns / 1ps

module tour_node_swap_improver
   import tnsi_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CountBits-1:0] csr_wdata,   // city_count
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [39:0]          req_tdata,   // from_city, to_city, distance, tour_pos, tour_city
   input  logic [1:0]           req_tuser,   // op
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [39:0]          rsp_tdata,   // out_pos, out_city, tour_length, zero pad
   output logic                 rsp_tlast    // last
);

   tnsi_cmd_type  cmd;
   tnsi_stat_type stat;

   tnsi_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .stat       (stat),
      .cmd        (cmd)
   );

   tnsi_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: sim/tnsi_checker.sv
// Checker for the tour node-swap improver: predicts result words and compares.
`timescale 1ns / 1ps

module tnsi_checker
   import tnsi_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CountBits-1:0] csr_wdata,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  logic [39:0]          req_tdata,
   input  logic [1:0]           req_tuser,
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic [39:0]          rsp_tdata,
   input  logic                 rsp_tlast,
   output int                   fail_count,
   output int                   tour_words_due,
   output int                   tour_words_seen
);

   typedef struct {
      logic [CityBits-1:0] pos;
      logic [CityBits-1:0] city;
      logic [LenBits-1:0]  len;
      logic                last;
   } tour_word_type;

   logic [DistBits-1:0]  dist_mem [MaxCities][MaxCities];
   logic [CityBits-1:0]  tour_mem [MaxCities];
   logic [CountBits-1:0] count_reg;
   tour_word_type        tour_due_q [$];

   assign tour_words_due = tour_due_q.size();

   // Saturate the register to the usable city range
   function automatic int used_count(input logic [CountBits-1:0] c);
      if (c < CountMin) return CountMin;
      if (c > CountMax) return CountMax;
      return c;
   endfunction

   // Run the swap sweeps on the local tour copy, then queue the tour words
   task automatic improve_and_queue(input int n);
      int                  p1, p2, p3;
      logic [DistBits:0]   now_sum, alt_sum;
      logic [CityBits-1:0] a, b, c, d, t;
      logic [LenBits:0]    acc;
      tour_word_type       w;
      for (int span = n; span > 0; span--) begin
         for (int j = span; j > 3; j--) begin
            for (int i = 0; i < n; i++) begin
               p1 = (i + 1) % n;
               p2 = (i + j - 2) % n;
               p3 = (i + j - 1) % n;
               a = tour_mem[i];
               b = tour_mem[p1];
               c = tour_mem[p2];
               d = tour_mem[p3];
               now_sum = dist_mem[a][b] + dist_mem[c][d];
               alt_sum = dist_mem[a][c] + dist_mem[b][d];
               if (now_sum > alt_sum) begin
                  t = tour_mem[p1];
                  tour_mem[p1] = tour_mem[p2];
                  tour_mem[p2] = t;
               end
            end
         end
      end
      acc = '0;
      for (int i = 0; i < n; i++) begin
         acc = acc + dist_mem[tour_mem[i]][tour_mem[(i + 1) % n]];
         if (acc > LenMax) acc = LenMax;
      end
      for (int k = 0; k < n; k++) begin
         w.pos  = k[CityBits-1:0];
         w.city = tour_mem[k];
         w.len  = acc[LenBits-1:0];
         w.last = (k == n - 1);
         tour_due_q.push_back(w);
      end
   endtask

   // Track requests and compare every result word against the oldest due word
   always @(posedge clock) begin
      tour_word_type exp_w;
      if (reset) begin
         count_reg       <= CountReset;
         fail_count      <= 0;
         tour_words_seen <= 0;
         tour_due_q.delete();
      end else begin
         if (csr_we) count_reg <= csr_wdata;
         if (req_tvalid && req_tready) begin
            case (req_tuser)
               OP_LOAD_DIST: dist_mem[req_tdata[4:0]][req_tdata[9:5]] = req_tdata[29:10];
               OP_LOAD_TOUR: tour_mem[req_tdata[34:30]] = req_tdata[39:35];
               OP_RUN:       improve_and_queue(used_count(count_reg));
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            tour_words_seen <= tour_words_seen + 1;
            if (tour_due_q.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10)
                  $display("ERROR: result word with none due: pos %0d city %0d",
                           rsp_tdata[4:0], rsp_tdata[9:5]);
            end else begin
               exp_w = tour_due_q.pop_front();
               if (rsp_tdata[4:0] !== exp_w.pos || rsp_tdata[9:5] !== exp_w.city ||
                   rsp_tdata[34:10] !== exp_w.len || rsp_tdata[39:35] !== 5'd0 ||
                   rsp_tlast !== exp_w.last) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10)
                     $display({"ERROR: exp pos %0d city %0d len %0d last %0b, ",
                               "got pos %0d city %0d len %0d last %0b pad %0h"},
                              exp_w.pos, exp_w.city, exp_w.len, exp_w.last,
                              rsp_tdata[4:0], rsp_tdata[9:5], rsp_tdata[34:10],
                              rsp_tlast, rsp_tdata[39:35]);
               end
            end
         end
      end
   end

endmodule

FILE: sim/tb_tour_node_swap_improver.sv
// Stimulus and verdict for the tour node-swap improver.
`timescale 1ns / 1ps

module tb_tour_node_swap_improver;
   import tnsi_pkg::*;

   localparam int StallLimit = 600000;
   // Cities that ever appear in a tour; the first fill loads all distances among them
   localparam int DistCities = 12;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we = 1'b0;
   logic [CountBits-1:0] csr_wdata = '0;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [39:0]          req_tdata = '0;   // from_city, to_city, distance, tour_pos, tour_city
   logic [1:0]           req_tuser = '0;   // op
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [39:0]          rsp_tdata;        // out_pos, out_city, tour_length, zero pad
   logic                 rsp_tlast;        // last

   int fail_count, tour_words_due, tour_words_seen;
   int tx_idle = 0, rx_idle = 0;
   int word_count = 0, run_count = 0, quiet_cycles = 0;
   int cur_n;
   int perm [DistCities];

   always #10 clock = ~clock;

   tour_node_swap_improver i_dut (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );

   tnsi_checker i_checker (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast), .fail_count(fail_count),
      .tour_words_due(tour_words_due), .tour_words_seen(tour_words_seen)
   );

   // Stall the result side at random
   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= rx_idle);

   // Watchdog: count cycles in which no word moves on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
         $display("Watchdog expired with %0d tour words still due", tour_words_due);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Offer one request word, idling at random first; returns at a falling edge
   task automatic send_word(input logic [1:0] op, input logic [39:0] data);
      while ($urandom_range(99) < tx_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      word_count++;
      if (op == OP_RUN) run_count++;
      @(negedge clock);
   endtask

   task automatic load_dist(input int from_c, input int to_c, input logic [19:0] dist_val);
      logic [39:0] d;
      d        = 40'({$urandom, $urandom});
      d[4:0]   = from_c[4:0];
      d[9:5]   = to_c[4:0];
      d[29:10] = dist_val;
      send_word(OP_LOAD_DIST, d);
   endtask

   task automatic load_tour(input int pos, input int city);
      logic [39:0] d;
      d        = 40'({$urandom, $urandom});
      d[34:30] = pos[4:0];
      d[39:35] = city[4:0];
      send_word(OP_LOAD_TOUR, d);
   endtask

   task automatic run_tour();
      send_word(OP_RUN, 40'({$urandom, $urandom}));
   endtask

   // Hold the sender until all tour words are back, let the block settle, then write
   task automatic write_count(input logic [CountBits-1:0] value);
      req_tvalid <= 1'b0;
      while (tour_words_due != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      if (value < CountMin) cur_n = CountMin;
      else if (value > CountMax) cur_n = CountMax;
      else cur_n = value;
   endtask

   // Load a shuffled tour of the loaded cities, repeating them past DistCities
   task automatic load_perm();
      int j, t;
      for (int i = 0; i < DistCities; i++) perm[i] = i;
      for (int i = DistCities - 1; i > 0; i--) begin
         j = $urandom_range(i);
         t = perm[i]; perm[i] = perm[j]; perm[j] = t;
      end
      for (int i = 0; i < cur_n; i++) load_tour(i, perm[i % DistCities]);
   endtask

   function automatic logic [19:0] rand_dist();
      case ($urandom_range(7))
         0:       return 20'h0;
         1:       return 20'hFFFFF;
         2, 3:    return 20'($urandom);
         default: return 20'($urandom_range(4095));
      endcase
   endfunction

   initial begin
      int seen, seen_word;
      cur_n = CountReset;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      tx_idle = 24;
      rx_idle = 82;

      // Fill the distances among the used cities and every tour slot
      for (int f = 0; f < DistCities; f++)
         for (int t = 0; t < DistCities; t++) load_dist(f, t, rand_dist());
      for (int i = 0; i < MaxCities; i++) load_tour(i, i % DistCities);

      // Directed: distance extremes, top table corner, top tour slot, unused op,
      // counts out of range
      load_dist(DistCities - 1, 0, 20'hFFFFF);
      load_dist(0, DistCities - 1, 20'h0);
      load_dist(31, 31, 20'hFFFFF);
      load_tour(31, DistCities - 1);
      load_tour(0, DistCities - 1);
      send_word(OP_SPARE, 40'hFF_FFFF_FFFF);
      write_count(6'd0);
      run_tour();
      write_count(6'd63);
      load_tour(1, 0);
      run_tour();
      write_count(6'd4);
      load_tour(2, 2);
      load_tour(3, 3);
      run_tour();
      send_word(OP_SPARE, 40'h0);

      // Random rounds in three idling phases
      for (int ph = 0; ph < 3; ph++) begin
         tx_idle = (ph == 0) ? 24 : (ph == 1) ? 82 : 0;
         rx_idle = (ph == 0) ? 82 : (ph == 1) ? 24 : 0;
         seen = word_count;
         while (word_count - seen < 30) begin
            if ($urandom_range(5) == 0) write_count(6'($urandom_range(12)));
            else write_count(6'($urandom_range(9, 4)));
            if ($urandom_range(9) < 8) load_perm();
            else repeat ($urandom_range(cur_n)) load_tour($urandom_range(31),
                                                          $urandom_range(DistCities - 1));
            repeat ($urandom_range(6))
               load_dist($urandom_range(31), $urandom_range(31), rand_dist());
            if ($urandom_range(7) == 0) send_word(OP_SPARE, 40'({$urandom, $urandom}));
            run_tour();
            // Back-to-back runs now and then, with no count write or load in between
            if ($urandom_range(3) == 0) run_tour();
         end
      end

      // Full table size once more over the tour store as it stands
      write_count(6'd32);
      run_tour();

      req_tvalid <= 1'b0;
      while (tour_words_due != 0) @(negedge clock);
      repeat (50) @(negedge clock);

      seen_word = tour_words_seen;
      $display("Covered %0d request words and %0d tour runs, city counts 4 to 32,",
               word_count, run_count);
      $display("with %0d tour words checked under three stall patterns.", seen_word);
      if (fail_count == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule

FILE: filelist.f
src/tnsi_pkg.sv
src/tnsi_ctrl.sv
src/tnsi_dpath.sv
src/tour_node_swap_improver.sv
sim/tnsi_checker.sv
sim/tb_tour_node_swap_improver.sv
